FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JMFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define JMFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// invariant
`define JMFB_ASSERT_ALW(lbl, cond) \
  `JMFB_ASSERT_IMP(lbl, 1'b1, cond)

`endif

FILE: rtl/jmfb_pkg.sv
// ----------------------------------------------------------------------------
// jmfb_pkg
// Shared constants, coefficient table and control types of the filter bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package jmfb_pkg;

  localparam int JOINT_COUNT_DEF = 32;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int COEF_W          = 25;
  localparam int TAP_COUNT       = 9;
  localparam int HIST_DEPTH      = 4;

  localparam logic [1:0] LVL_SOFT   = 2'd0;
  localparam logic [1:0] LVL_MEDIUM = 2'd1;
  localparam logic [1:0] LVL_HARD   = 2'd2;
  localparam logic [1:0] LVL_UNUSED = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_TAB [3][3][TAP_COUNT] = '{
    '{
      '{25'sd776550, 25'sd580191, 25'sd732700, 25'sd438987, 25'sd194777,
        -25'sd5445228, 25'sd6137983, -25'sd2980683, 25'sd850956},
      '{25'sd1137694, 25'sd555189, -25'sd204375, -25'sd748022, -25'sd740487,
        -25'sd1224517, 25'sd2141047, -25'sd65340, 25'sd1191},
      '{25'sd461020, -25'sd541117, -25'sd156308, 25'sd90631, 25'sd145355,
        -25'sd3470764, 25'sd3401906, -25'sd1480958, 25'sd276779}
    },
    '{
      '{25'sd640156, 25'sd139872, 25'sd326129, 25'sd279821, 25'sd58278,
        -25'sd7324189, 25'sd7278828, -25'sd3453036, 25'sd752233},
      '{25'sd827821, -25'sd23726, -25'sd134994, -25'sd461141, -25'sd207960,
        -25'sd4140105, 25'sd3261014, -25'sd925617, 25'sd118004},
      '{-25'sd333687, 25'sd583306, -25'sd200988, -25'sd13195, -25'sd35436,
        -25'sd6589375, 25'sd6120382, -25'sd3008886, 25'sd624115}
    },
    '{
      '{25'sd587615, -25'sd144190, 25'sd190423, 25'sd41831, 25'sd3559,
        -25'sd8046948, 25'sd6681266, -25'sd2491290, 25'sd341705},
      '{-25'sd647254, 25'sd730813, -25'sd75031, -25'sd9637, 25'sd1109,
        -25'sd8629759, 25'sd7795977, -25'sd3362931, 25'sd549774},
      '{-25'sd309955, 25'sd566913, -25'sd215167, -25'sd30584, -25'sd11206,
        -25'sd6829530, 25'sd5950707, -25'sd2610293, 25'sd455201}
    }
  };

  typedef struct packed {
    logic       run;
    logic [1:0] phase;
  } jmfb_ctl_t;

  // feedback taps carry the negated a coefficients
  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] lvl,
                                                    input logic [1:0] filt,
                                                    input logic [3:0] tap);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (lvl != LVL_UNUSED && filt != 2'd3 && tap < 4'(TAP_COUNT)) begin
      c = COEF_TAB[lvl][filt][tap];
      if (tap >= 4'd5) c = -c;
    end
    return c;
  endfunction

endpackage

FILE: rtl/joint_motion_filter_bank_core.sv
// ----------------------------------------------------------------------------
// joint_motion_filter_bank_core
// Per-joint smoothing, velocity and acceleration IIR bank with peak flags.
// ----------------------------------------------------------------------------
// Flow: an accepted input waits in the input buffer, then runs the four MAC
// phases of the nine lanes with the history row read from and written back to
// the joint RAM; the next input can be buffered while one is processed.
// Reset: clears the filter level, the per-joint row valid bits and all
// handshake state; unwritten history rows read as zero, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module joint_motion_filter_bank_core
  import jmfb_pkg::*;
#(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint_index[4:0], pos_x[36:5], pos_y[68:37], pos_z[100:69], zero fill
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // joint_out[4:0], smooth_x/y/z, vel_x/y/z, acc_x/y/z (32 bits each),
  // vel_extrema[298:293], acc_extrema[304:299], zero fill
  output logic [311:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i
);

  localparam int DW    = DATA_WIDTH;
  localparam int JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int ROW_W = 3 * 4 * HIST_DEPTH * DW;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_FIN} state_e;

  function automatic logic signed [DW-1:0] sat_in(input logic [31:0] v);
    logic signed [DW+31:0] e;
    logic signed [DW+31:0] hi;
    e  = (DW+32)'($signed(v));
    hi = (DW+32)'({1'b0, {(DW-1){1'b1}}});
    if (e > hi) return DW'(hi);
    if (e < -hi - (DW+32)'(1)) return DW'(-hi - (DW+32)'(1));
    return DW'(e);
  endfunction

  function automatic logic [31:0] to32(input logic signed [DW-1:0] v);
    return 32'(v);
  endfunction

  // 1 maximum, 2 minimum, 0 none
  function automatic logic [1:0] extremum(input logic signed [DW-1:0] h0,
                                          input logic signed [DW-1:0] h1,
                                          input logic signed [DW-1:0] h2,
                                          input logic signed [DW-1:0] h3,
                                          input logic signed [DW-1:0] nw);
    if (h1 > h3 && h1 > h2 && h1 >= h0 && h1 >= nw) return 2'd1;
    if (h1 < h3 && h1 < h2 && h1 <= h0 && h1 <= nw) return 2'd2;
    return 2'd0;
  endfunction

  state_e state_q;
  logic [1:0] phase_q;
  logic [1:0] level_q;
  logic in_full_q;
  logic [103:0] in_data_q;
  logic [4:0] joint_q;
  logic in_range_q;
  logic row_ok_q;
  logic signed [DW-1:0] x_q [3];
  logic [JOINT_COUNT-1:0] vld_q;
  logic out_valid_q;
  logic [311:0] out_data_q;

  logic s_acc;
  logic start;
  logic fin_go;
  logic [4:0] in_joint;
  logic in_range;
  logic [JW-1:0] addr_q_w;
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_new;
  logic [311:0] res_data;
  jmfb_ctl_t ctl;
  logic signed [DW-1:0] xh_w [3][HIST_DEPTH];
  logic signed [DW-1:0] yh_w [9][HIST_DEPTH];
  logic signed [DW-1:0] y_w [9];

  assign s_axis_tready = !in_full_q;
  assign s_acc         = s_axis_tvalid && !in_full_q;
  assign start         = (state_q == ST_IDLE) && in_full_q;
  assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign in_joint      = in_data_q[4:0];
  assign in_range      = {27'b0, in_joint} < 32'(JOINT_COUNT);
  assign addr_q_w      = JW'(joint_q);
  assign cfg_ready_o   = 1'b1;
  assign ctl.run       = (state_q == ST_MAC);
  assign ctl.phase     = phase_q;
  assign row           = row_ok_q ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 2'd0;
      level_q     <= LVL_SOFT;
      in_full_q   <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_data_i != LVL_UNUSED) level_q <= cfg_data_i;
      if (s_acc) in_full_q <= 1'b1;
      else if (start) in_full_q <= 1'b0;
      if (fin_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            phase_q <= 2'd0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd3) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            if (in_range_q) vld_q[addr_q_w] <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) in_data_q <= s_axis_tdata;
    if (start) begin
      joint_q    <= in_joint;
      in_range_q <= in_range;
      row_ok_q   <= in_range && vld_q[JW'(in_joint)];
      x_q[0]     <= sat_in(in_data_q[36:5]);
      x_q[1]     <= sat_in(in_data_q[68:37]);
      x_q[2]     <= sat_in(in_data_q[100:69]);
    end
    if (fin_go) out_data_q <= res_data;
  end

  jmfb_ram #(.WIDTH(ROW_W), .DEPTH(JOINT_COUNT)) u_ram (
    .clk_i  (clk_i),
    .we_i   (fin_go && in_range_q),
    .waddr_i(addr_q_w),
    .wdata_i(row_new),
    .re_i   (start && in_range),
    .raddr_i(JW'(in_joint)),
    .rdata_o(rdata)
  );

  // row word: axis*16 + hist*4 + age, hist 0 raw, 1 smooth, 2 vel, 3 acc
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        xh_w[a][k] = row[(a*16+k)*DW +: DW];
        for (int f = 0; f < 3; f++) begin
          yh_w[a*3+f][k] = row[(a*16+(f+1)*4+k)*DW +: DW];
        end
      end
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_lane
    jmfb_lane #(.DATA_WIDTH(DW), .FILT(2'(l % 3))) u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .level_i(level_q),
      .x_i    (x_q[l/3]),
      .xh_i   (xh_w[l/3]),
      .yh_i   (yh_w[l]),
      .y_o    (y_w[l])
    );
  end

  always_comb begin
    logic [5:0] vm;
    logic [5:0] am;
    logic [1:0] e;
    vm = '0;
    am = '0;
    row_new = '0;
    for (int a = 0; a < 3; a++) begin
      row_new[(a*16)*DW +: DW] = x_q[a];
      for (int k = 1; k < HIST_DEPTH; k++) begin
        row_new[(a*16+k)*DW +: DW] = xh_w[a][k-1];
      end
      for (int f = 0; f < 3; f++) begin
        row_new[(a*16+(f+1)*4)*DW +: DW] = y_w[a*3+f];
        for (int k = 1; k < HIST_DEPTH; k++) begin
          row_new[(a*16+(f+1)*4+k)*DW +: DW] = yh_w[a*3+f][k-1];
        end
      end
      e = extremum(yh_w[a*3+1][0], yh_w[a*3+1][1], yh_w[a*3+1][2], yh_w[a*3+1][3],
                   y_w[a*3+1]);
      vm[a]   = (e == 2'd1);
      vm[a+3] = (e == 2'd2);
      e = extremum(yh_w[a*3+2][0], yh_w[a*3+2][1], yh_w[a*3+2][2], yh_w[a*3+2][3],
                   y_w[a*3+2]);
      am[a]   = (e == 2'd1);
      am[a+3] = (e == 2'd2);
    end
    res_data = '0;
    res_data[4:0] = joint_q;
    if (in_range_q) begin
      for (int a = 0; a < 3; a++) begin
        for (int f = 0; f < 3; f++) begin
          res_data[5+(f*3+a)*32 +: 32] = to32(y_w[a*3+f]);
        end
      end
      res_data[298:293] = vm;
      res_data[304:299] = am;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `JMFB_ASSERT_ALW(a_level_legal, level_q != LVL_UNUSED)
  `JMFB_ASSERT_NXT(a_mac_to_fin, state_q == ST_MAC && phase_q == 2'd3, state_q == ST_FIN)
  `JMFB_ASSERT_NXT(a_fin_result, fin_go, m_axis_tvalid)
  `JMFB_ASSERT_IMP(a_start_idle, start, !out_valid_q || state_q == ST_IDLE)

endmodule

FILE: rtl/jmfb_ram.sv
// ----------------------------------------------------------------------------
// jmfb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jmfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/jmfb_lane.sv
// ----------------------------------------------------------------------------
// jmfb_lane
// One fourth-order IIR lane: three taps per phase, rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jmfb_lane
  import jmfb_pkg::*;
#(
  parameter int         DATA_WIDTH = DATA_WIDTH_DEF,
  parameter logic [1:0] FILT       = 2'd0
) (
  input  logic                         clk_i,
  input  jmfb_ctl_t                    ctl_i,
  input  logic [1:0]                   level_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] xh_i [HIST_DEPTH],
  input  logic signed [DATA_WIDTH-1:0] yh_i [HIST_DEPTH],
  output logic signed [DATA_WIDTH-1:0] y_o
);

  localparam int PW = DATA_WIDTH + COEF_W;
  localparam int AW = PW + 4;
  localparam int RW = AW - 22;

  logic signed [DATA_WIDTH-1:0] d [TAP_COUNT];
  logic signed [PW-1:0] prod_d [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [AW-1:0] psum;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] rnd;
  logic signed [RW-1:0] sh;
  logic signed [RW-1:0] hi;
  logic signed [RW-1:0] lo;

  always_comb begin
    logic [3:0] idx;
    d[0] = x_i;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      d[1+i] = xh_i[i];
      d[5+i] = yh_i[i];
    end
    for (int j = 0; j < 3; j++) begin
      idx = 4'(ctl_i.phase) * 4'd3 + 4'(j);
      if (ctl_i.phase != 2'd3) begin
        prod_d[j] = PW'(d[idx]) * PW'(coef(level_i, FILT, idx));
      end else begin
        prod_d[j] = '0;
      end
    end
  end

  assign psum = AW'(prod_q[0]) + AW'(prod_q[1]) + AW'(prod_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      prod_q <= prod_d;
      if (ctl_i.phase == 2'd1) acc_q <= psum;
      else if (ctl_i.phase != 2'd0) acc_q <= acc_q + psum;
    end
  end

  assign rnd = acc_q + AW'(2097152);
  assign sh  = RW'(rnd >>> 22);
  assign hi  = RW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  assign lo  = -hi - RW'(1);
  assign y_o = (sh > hi) ? DATA_WIDTH'(hi) : (sh < lo) ? DATA_WIDTH'(lo) : DATA_WIDTH'(sh);

endmodule
